// ===== src/mav_pkg.sv =====
package mav_pkg;

    localparam int WINDOW_MAX = 256;
    localparam int SAMPLE_W   = 32;
    localparam int WC_W       = 9;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic                present;
        logic [SAMPLE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== src/mav_ifs.sv =====
interface mav_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mav_pkg::SAMPLE_W-1:0] sample;
    logic                                sample_present;
    logic                                start_series;

    modport source (output valid, output sample, output sample_present,
                    output start_series, input ready);
    modport sink (input valid, input sample, input sample_present,
                  input start_series, output ready);
endinterface

interface mav_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mav_pkg::SAMPLE_W-1:0] average;
    logic                                average_present;

    modport source (output valid, output average, output average_present, input ready);
    modport sink (input valid, input average, input average_present, output ready);
endinterface

interface mav_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mav_pkg::WC_W-1:0]    window_count;

    modport source (output valid, output window_count, input ready);
    modport sink (input valid, input window_count, output ready);
endinterface

// ===== src/mav_ring.sv =====
module mav_ring (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [mav_pkg::PTR_W-1:0]  i_waddr,
    input  mav_pkg::t_entry            i_wdata,
    input  logic [mav_pkg::PTR_W-1:0]  i_raddr,
    output mav_pkg::t_entry            o_rdata
);

    mav_pkg::t_entry mem [mav_pkg::WINDOW_MAX];
    mav_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mav_div.sv =====
module mav_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mav_pkg::t_div_req i_req,
    output mav_pkg::t_div_rsp o_rsp
);

    logic [mav_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;
    logic                          r_neg;
    logic [mav_pkg::SUM_W-1:0]     r_quo;
    logic [mav_pkg::CNT_W-1:0]     r_rem;
    logic [mav_pkg::CNT_W-1:0]     r_divisor;

    logic [mav_pkg::CNT_W:0]       rem_sh;
    logic                          q_bit;
    logic [mav_pkg::CNT_W-1:0]     n_rem;
    logic [mav_pkg::SAMPLE_W-1:0]  q_low;

    always_comb begin
        rem_sh = {r_rem, r_quo[mav_pkg::SUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_divisor});
        if (q_bit) begin
            n_rem = mav_pkg::CNT_W'(rem_sh - {1'b0, r_divisor});
        end else begin
            n_rem = rem_sh[mav_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == mav_pkg::DIV_CNT_W'(1));
            if (i_req.start) begin
                r_cnt <= mav_pkg::DIV_CNT_W'(mav_pkg::SUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg     <= i_req.dividend[mav_pkg::SUM_W-1];
            r_quo     <= i_req.dividend[mav_pkg::SUM_W-1] ? -i_req.dividend : i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[mav_pkg::SUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign q_low          = r_quo[mav_pkg::SAMPLE_W-1:0];
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -q_low : q_low;

endmodule

// ===== src/moving_average_missing_aware.sv =====
// Sliding-window average over a stream of Q16.16 samples that may be missing.
// Samples arrive as items on i_in with a present flag and a start-of-series flag.
// Each accepted item yields exactly one item on o_out: the window sum divided
// by the window length, truncated toward zero, with average_present
// low (and average zero) while every sample of the window so far is missing.
// The window length is written through i_cfg, which is always ready; a value of
// 0 acts as 1 and one above 256 as 256. A write also clears the window so that
// the next sample starts a new series. Window samples live in a 256-entry ring
// memory: the oldest sample is read, the new one written in the cycle after.
// The division runs in a restoring divider that retires one quotient
// bit per cycle over the 40-bit sum; an item passes through the update,
// launch and divide states before its result is loaded into the output
// register. One item is processed at a time.
// A finished result sits in an output register; while the receiver stalls
// the block still accepts and processes the next item and holds its result
// until the output register is free.
// After reset the window length is one and the window is empty; the ring
// needs no clearing because an entry is only used after it has been written.
module moving_average_missing_aware (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mav_in_if.sink    i_in,
    mav_out_if.source o_out,
    mav_cfg_if.sink   i_cfg
);

    mav_pkg::t_state                      r_state;
    mav_pkg::t_state                      n_state;
    logic [mav_pkg::WC_W-1:0]             r_wc;
    logic signed [mav_pkg::SUM_W-1:0]     r_sum;
    logic [mav_pkg::CNT_W-1:0]            r_missing;
    logic [mav_pkg::CNT_W-1:0]            r_fill;
    logic [mav_pkg::PTR_W-1:0]            r_wp;
    logic signed [mav_pkg::SAMPLE_W-1:0]  r_sample;
    logic                                 r_present;
    logic                                 r_avg_present;
    logic                                 r_out_valid;
    logic signed [mav_pkg::SAMPLE_W-1:0]  r_out_avg;
    logic                                 r_out_present;

    logic signed [mav_pkg::SUM_W-1:0]     n_sum;
    logic [mav_pkg::CNT_W-1:0]            n_missing;
    logic [mav_pkg::CNT_W-1:0]            n_fill;
    logic [mav_pkg::PTR_W-1:0]            n_wp;

    logic                                 in_fire;
    logic                                 cfg_fire;
    logic                                 out_load;
    logic [mav_pkg::CNT_W-1:0]            wlen;
    logic [mav_pkg::PTR_W-1:0]            wp_eff;
    logic [mav_pkg::CNT_W-1:0]            wp_ext;
    logic [mav_pkg::CNT_W-1:0]            old_full;
    logic signed [mav_pkg::SUM_W-1:0]     sum_a;
    logic [mav_pkg::CNT_W-1:0]            miss_a;
    mav_pkg::t_entry                      old_entry;
    mav_pkg::t_entry                      new_entry;
    mav_pkg::t_div_req                    div_req;
    mav_pkg::t_div_rsp                    div_rsp;

    assign in_fire     = i_in.valid && i_in.ready;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_state == mav_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_wc == '0) begin
            wlen = mav_pkg::CNT_W'(1);
        end else if (32'(r_wc) > 32'(mav_pkg::WINDOW_MAX)) begin
            wlen = mav_pkg::CNT_W'(mav_pkg::WINDOW_MAX);
        end else begin
            wlen = mav_pkg::CNT_W'(r_wc);
        end
    end

    always_comb begin
        wp_eff = i_in.start_series ? '0 : r_wp;
        wp_ext = mav_pkg::CNT_W'(wp_eff);
        if (wp_ext >= wlen) begin
            old_full = wp_ext - wlen;
        end else begin
            old_full = wp_ext + mav_pkg::CNT_W'(mav_pkg::WINDOW_MAX) - wlen;
        end
    end

    assign new_entry.present = r_present;
    assign new_entry.value   = r_sample;

    mav_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == mav_pkg::ST_UPDATE),
        .i_waddr (r_wp),
        .i_wdata (new_entry),
        .i_raddr (old_full[mav_pkg::PTR_W-1:0]),
        .o_rdata (old_entry)
    );

    always_comb begin
        sum_a     = r_sum + (r_present ? mav_pkg::SUM_W'(r_sample) : '0);
        miss_a    = r_missing + mav_pkg::CNT_W'(!r_present);
        n_sum     = sum_a;
        n_missing = miss_a;
        if (r_fill >= wlen) begin
            if (old_entry.present) begin
                n_sum = sum_a - mav_pkg::SUM_W'($signed(old_entry.value));
            end else if (miss_a != '0) begin
                n_missing = miss_a - 1'b1;
            end
            n_fill = wlen;
        end else begin
            n_fill = r_fill + 1'b1;
        end
        if (32'(r_wp) == mav_pkg::WINDOW_MAX - 1) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + 1'b1;
        end
    end

    mav_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state          = r_state;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_sum;
        div_req.divisor  = wlen;
        case (r_state)
            mav_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = mav_pkg::ST_UPDATE;
                end
            end
            mav_pkg::ST_UPDATE: begin
                n_state = mav_pkg::ST_LAUNCH;
            end
            mav_pkg::ST_LAUNCH: begin
                div_req.start = 1'b1;
                n_state       = mav_pkg::ST_DIVIDE;
            end
            mav_pkg::ST_DIVIDE: begin
                if (div_rsp.done) begin
                    if (!r_out_valid || o_out.ready) begin
                        out_load = 1'b1;
                        n_state  = mav_pkg::ST_IDLE;
                    end else begin
                        n_state = mav_pkg::ST_HOLD;
                    end
                end
            end
            mav_pkg::ST_HOLD: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = mav_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mav_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mav_pkg::ST_IDLE;
            r_wc        <= mav_pkg::WC_W'(1);
            r_sum       <= '0;
            r_missing   <= '0;
            r_fill      <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_fire) begin
                r_wc      <= i_cfg.window_count;
                r_sum     <= '0;
                r_missing <= '0;
                r_fill    <= '0;
                r_wp      <= '0;
            end else if (in_fire && i_in.start_series) begin
                r_sum     <= '0;
                r_missing <= '0;
                r_fill    <= '0;
                r_wp      <= '0;
            end else if (r_state == mav_pkg::ST_UPDATE) begin
                r_sum     <= n_sum;
                r_missing <= n_missing;
                r_fill    <= n_fill;
                r_wp      <= n_wp;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample  <= i_in.sample;
            r_present <= i_in.sample_present;
        end
        if (r_state == mav_pkg::ST_UPDATE) begin
            r_avg_present <= !(n_missing >= n_fill);
        end
        if (out_load) begin
            r_out_avg     <= r_avg_present ? div_rsp.quotient : '0;
            r_out_present <= r_avg_present;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.average         = r_out_avg;
    assign o_out.average_present = r_out_present;

endmodule

// ===== src/mav_chk.sv =====
module mav_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [mav_pkg::SAMPLE_W-1:0] i_out_average,
    input logic                                i_out_present
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_average)
            && $stable(i_out_present))
        else $error("Stalled output item changed or vanished.");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_present |-> i_out_average == '0)
        else $error("Missing result carries a nonzero average.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("Block not empty after reset.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Input accepted while an item is in progress.");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("Result appeared right after acceptance.");

endmodule

bind moving_average_missing_aware mav_chk u_mav_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_average (o_out.average),
    .i_out_present (o_out.average_present)
);
